[hw/rtl/beep_pkg.sv]
// ----------------------------------------------------------------------------
// beep_pkg
// Shared widths, command codes, mode codes and reset values for the beeper
// envelope sequencer.
// ----------------------------------------------------------------------------
package beep_pkg;

	localparam int unsigned OP_W    = 3;
	localparam int unsigned VALUE_W = 16;
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned REG_W   = 16;
	localparam int unsigned CFG_IDX_W = 2;

	typedef logic [OP_W-1:0]    op_t;
	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [MODE_W-1:0]  mode_t;
	typedef logic [REG_W-1:0]   reg_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// Command codes.
	localparam op_t OP_TICK       = 3'd0;
	localparam op_t OP_START_PER  = 3'd1;
	localparam op_t OP_RETUNE     = 3'd2;
	localparam op_t OP_STOP       = 3'd3;
	localparam op_t OP_START_FIN  = 3'd4;

	// Run modes.
	localparam mode_t MODE_IDLE     = 2'd0;
	localparam mode_t MODE_PERIODIC = 2'd1;
	localparam mode_t MODE_FINITE   = 2'd2;

	// Configuration register indexes.
	localparam cfg_idx_t CFG_ON_MIN  = 2'd0;
	localparam cfg_idx_t CFG_ON_MAX  = 2'd1;
	localparam cfg_idx_t CFG_HYST    = 2'd2;
	localparam cfg_idx_t CFG_FIN_PER = 2'd3;

	// Reset values.
	localparam reg_t RST_ON_MIN   = 16'd40;
	localparam reg_t RST_ON_MAX   = 16'd150;
	localparam reg_t RST_HYST     = 16'd200;
	localparam reg_t RST_FIN_PER  = 16'd250;
	localparam reg_t RST_PERIOD   = 16'd1000;
	localparam reg_t RST_ON_TIME  = 16'd120;

endpackage

[hw/rtl/beep_cmd_if.sv]
// ----------------------------------------------------------------------------
// beep_cmd_if
// Command channel: valid/ready handshake carrying an op code and a value.
// ----------------------------------------------------------------------------
interface beep_cmd_if;
	import beep_pkg::*;

	logic   valid;
	logic   ready;
	op_t    op;
	value_t value;

	modport source (output valid, output op, output value, input ready);
	modport sink   (input valid, input op, input value, output ready);

endinterface

[hw/rtl/beep_rsp_if.sv]
// ----------------------------------------------------------------------------
// beep_rsp_if
// Result channel: valid/ready handshake carrying buzzer level and run mode.
// ----------------------------------------------------------------------------
interface beep_rsp_if;
	import beep_pkg::*;

	logic  valid;
	logic  ready;
	logic  buzzer;
	mode_t mode;

	modport source (output valid, output buzzer, output mode, input ready);
	modport sink   (input valid, input buzzer, input mode, output ready);

endinterface

[hw/rtl/beeper_envelope_sequencer.sv]
// ----------------------------------------------------------------------------
// beeper_envelope_sequencer
// On/off envelope generator for an active buzzer, advanced by tick commands.
// ----------------------------------------------------------------------------
// Timing: a command is held in the command register, and its result moves to the
//   result register when that register is empty or being drained.
// Throughput: one command per cycle while results are taken, set by the
//   state update between the command and result registers.
// Reset: arst_n clears all control state at once; the sequencer comes up idle
//   and silent with the default cadence and configuration registers.
module beeper_envelope_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  beep_pkg::cfg_idx_t  cfg_index,
	input  beep_pkg::reg_t      cfg_data,
	beep_cmd_if.sink            cmd,
	beep_rsp_if.source          rsp
);
	import beep_pkg::*;

	// Configuration registers.
	reg_t on_min_q, on_max_q, hyst_q, fin_per_q;

	// Sequencer state.
	mode_t  mode_q;
	reg_t   period_q;
	reg_t   on_time_q;
	reg_t   phase_q;
	reg_t   beeps_q;
	logic   buzz_q;

	// Command register (stage 1) and result register (stage 2).
	logic   valid_s1;
	op_t    op_s1;
	value_t value_s1;
	logic   valid_s2;
	logic   buzz_s2;
	mode_t  mode_s2;

	logic   adv;

	// The command stage moves on whenever the result register is empty or is
	// being drained in this cycle. A result that waits holds the command stage,
	// and intake stops once that stage is full.
	assign adv       = valid_s1 && (!valid_s2 || rsp.ready);
	assign cmd.ready = !valid_s1 || adv;

	assign rsp.valid  = valid_s2;
	assign rsp.buzzer = buzz_s2;
	assign rsp.mode   = mode_s2;

	// Configuration writes land directly; the user must write only while idle, as the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_min_q  <= RST_ON_MIN;
			on_max_q  <= RST_ON_MAX;
			hyst_q    <= RST_HYST;
			fin_per_q <= RST_FIN_PER;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ON_MIN:  on_min_q  <= cfg_data;
				CFG_ON_MAX:  on_max_q  <= cfg_data;
				CFG_HYST:    hyst_q    <= cfg_data;
				CFG_FIN_PER: fin_per_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A period of zero is taken as one. The finite period is clamped here too.
	reg_t cmd_per, fin_per;
	assign cmd_per = (value_s1 == '0) ? reg_t'(1) : value_s1;
	assign fin_per = (fin_per_q == '0) ? reg_t'(1) : fin_per_q;

	// Cadence: on time is half the period, clamped to the minimum, then to the
	// maximum (so the maximum wins when the two cross), then to the period.
	// Both start commands and retune share one cadence unit; the period source
	// is chosen by op code.
	reg_t cad_per, cad_half, cad_lo, cad_hi, cad_on;
	assign cad_per  = (op_s1 == OP_START_FIN) ? fin_per : cmd_per;
	assign cad_half = cad_per >> 1;
	assign cad_lo   = (cad_half < on_min_q) ? on_min_q : cad_half;
	assign cad_hi   = (cad_lo > on_max_q) ? on_max_q : cad_lo;
	assign cad_on   = (cad_hi >= cad_per) ? cad_per : cad_hi;

	// Retune distance from the current period.
	reg_t diff;
	logic retune_hit;
	assign diff       = (period_q > cmd_per) ? (period_q - cmd_per) : (cmd_per - period_q);
	assign retune_hit = diff > hyst_q;

	// Tick path.
	reg_t phase_inc, beeps_dec;
	assign phase_inc = phase_q + reg_t'(1);
	assign beeps_dec = (beeps_q != '0) ? (beeps_q - reg_t'(1)) : '0;

	// Next state.
	mode_t mode_d;
	reg_t  period_d, on_time_d, phase_d, beeps_d;
	logic  buzz_d;

	always_comb begin
		mode_d    = mode_q;
		period_d  = period_q;
		on_time_d = on_time_q;
		phase_d   = phase_q;
		beeps_d   = beeps_q;
		buzz_d    = buzz_q;
		case (op_s1)
			OP_TICK: begin
				if (mode_q != MODE_IDLE) begin
					phase_d = phase_inc;
					if (phase_inc == on_time_q) begin
						buzz_d = 1'b0;
					end
					// End of a period restarts the phase and, unless the
					// finite count just ran out, turns the buzzer back on.
					if (phase_inc >= period_q) begin
						phase_d = '0;
						buzz_d  = 1'b1;
						if (mode_q == MODE_FINITE) begin
							beeps_d = beeps_dec;
							if (beeps_dec == '0) begin
								mode_d = MODE_IDLE;
								buzz_d = 1'b0;
							end
						end
					end
				end
			end
			OP_START_PER: begin
				period_d  = cad_per;
				on_time_d = cad_on;
				phase_d   = '0;
				mode_d    = MODE_PERIODIC;
				buzz_d    = 1'b1;
			end
			OP_RETUNE: begin
				// Only period and on time change; phase, buzzer and mode stay.
				if (retune_hit) begin
					period_d  = cad_per;
					on_time_d = cad_on;
				end
			end
			OP_STOP: begin
				mode_d = MODE_IDLE;
				buzz_d = 1'b0;
			end
			OP_START_FIN: begin
				// A finite start with a count of zero behaves as a stop.
				if (value_s1 == '0) begin
					mode_d = MODE_IDLE;
					buzz_d = 1'b0;
				end else begin
					period_d  = cad_per;
					on_time_d = cad_on;
					phase_d   = '0;
					beeps_d   = value_s1;
					mode_d    = MODE_FINITE;
					buzz_d    = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Control and state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			mode_q    <= MODE_IDLE;
			period_q  <= RST_PERIOD;
			on_time_q <= RST_ON_TIME;
			phase_q   <= '0;
			beeps_q   <= '0;
			buzz_q    <= 1'b0;
		end else begin
			if (cmd.ready) begin
				valid_s1 <= cmd.valid;
			end
			if (adv) begin
				valid_s2  <= 1'b1;
				mode_q    <= mode_d;
				period_q  <= period_d;
				on_time_q <= on_time_d;
				phase_q   <= phase_d;
				beeps_q   <= beeps_d;
				buzz_q    <= buzz_d;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_s1    <= cmd.op;
			value_s1 <= cmd.value;
		end
		if (adv) begin
			buzz_s2 <= buzz_d;
			mode_s2 <= mode_d;
		end
	end

endmodule

[sim/beeper_envelope_sequencer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beeper_envelope_sequencer_tb
// Self-checking bench for the buzzer envelope sequencer. A scoreboard class
// keeps its own copy of the cadence, phase and beep-count state and predicts
// the buzzer level and run mode for every command transfer. Commands get
// random gaps and results random stalls, but for a closing phase at full
// rate; the configuration is changed between phases while the block is quiet.
// ----------------------------------------------------------------------------
module beeper_envelope_sequencer_tb;
	import beep_pkg::*;

	// Settle time after the drain gives the pipeline room to empty.
	localparam int unsigned SETTLE_CYCLES = 6;
	// Far beyond the slowest legal run.
	localparam int unsigned TIMEOUT_NS    = 2000000;

	// One expected result: what the buzzer and the mode read after a command.
	typedef struct packed {
		logic  buzzer;
		mode_t mode;
	} envelope_t;

	// The scoreboard mirrors the sequencer. Each accepted command moves the
	// mirrored state forward and queues the levels the block must report;
	// each accepted result is checked against the oldest queued entry.
	class envelope_scoreboard;
		reg_t        on_min;
		reg_t        on_max;
		reg_t        hysteresis;
		reg_t        finite_per;
		mode_t       run_mode;
		value_t      cur_period;
		value_t      on_ticks;
		value_t      phase;
		value_t      beep_count;
		logic        buzz_level;
		envelope_t   pending_q[$];
		int unsigned failures;

		function new();
			on_min     = RST_ON_MIN;
			on_max     = RST_ON_MAX;
			hysteresis = RST_HYST;
			finite_per = RST_FIN_PER;
			run_mode   = MODE_IDLE;
			cur_period = RST_PERIOD;
			on_ticks   = RST_ON_TIME;
			phase      = '0;
			beep_count = '0;
			buzz_level = 1'b0;
			failures   = 0;
		endfunction

		function void write_register(cfg_idx_t idx, reg_t data);
			case (idx)
				CFG_ON_MIN:  on_min = data;
				CFG_ON_MAX:  on_max = data;
				CFG_HYST:    hysteresis = data;
				CFG_FIN_PER: finite_per = data;
				default: ;
			endcase
		endfunction

		function int unsigned outstanding();
			return pending_q.size();
		endfunction

		// Half the period, pulled up to the minimum, down to the maximum and
		// finally down to the period itself. The maximum wins over the minimum.
		function void load_cadence(value_t p);
			value_t q;
			value_t on;
			q  = (p == '0) ? value_t'(1) : p;
			on = q >> 1;
			if (on < on_min) on = on_min;
			if (on > on_max) on = on_max;
			if (on >= q) on = q;
			cur_period = q;
			on_ticks   = on;
		endfunction

		function void note_command(op_t op, value_t value);
			value_t    p;
			value_t    diff;
			envelope_t next;
			case (op)
				OP_TICK: begin
					if (run_mode != MODE_IDLE) begin
						phase = phase + value_t'(1);
						if (phase == on_ticks) buzz_level = 1'b0;
						// A phase already past a shortened period ends the cycle too.
						if (phase >= cur_period) begin
							phase = '0;
							if (run_mode == MODE_FINITE && beep_count != '0)
								beep_count = beep_count - value_t'(1);
							if (run_mode == MODE_FINITE && beep_count == '0) begin
								run_mode   = MODE_IDLE;
								buzz_level = 1'b0;
							end else begin
								buzz_level = 1'b1;
							end
						end
					end
				end
				OP_START_PER: begin
					load_cadence(value);
					phase      = '0;
					run_mode   = MODE_PERIODIC;
					buzz_level = 1'b1;
				end
				OP_RETUNE: begin
					p    = (value == '0) ? value_t'(1) : value;
					diff = (cur_period > p) ? cur_period - p : p - cur_period;
					if (diff > hysteresis) load_cadence(p);
				end
				OP_STOP: begin
					run_mode   = MODE_IDLE;
					buzz_level = 1'b0;
				end
				OP_START_FIN: begin
					if (value == '0) begin
						run_mode   = MODE_IDLE;
						buzz_level = 1'b0;
					end else begin
						load_cadence(finite_per);
						phase      = '0;
						beep_count = value;
						run_mode   = MODE_FINITE;
						buzz_level = 1'b1;
					end
				end
				default: ;
			endcase
			next.buzzer = buzz_level;
			next.mode   = run_mode;
			pending_q.push_back(next);
		endfunction

		function void check_result(logic buzzer, mode_t mode);
			envelope_t want;
			if (pending_q.size() == 0) begin
				fail($sformatf("result with nothing outstanding: buzzer %0b mode %0d",
					buzzer, mode));
				return;
			end
			want = pending_q.pop_front();
			if (want.buzzer !== buzzer)
				fail($sformatf("buzzer: expected %0b, got %0b", want.buzzer, buzzer));
			if (want.mode !== mode)
				fail($sformatf("mode: expected %0d, got %0d", want.mode, mode));
		endfunction

		function void fail(string what);
			failures++;
			if (failures <= 10) $display("%0t ns: %s", $time, what);
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     cfg_we;
	cfg_idx_t cfg_index;
	reg_t     cfg_data;

	beep_cmd_if cmd();
	beep_rsp_if rsp();

	envelope_scoreboard board = new();

	// Both sides may pause while this is set; the closing phase clears it so
	// the block also runs at full rate for a stretch.
	bit          idling;
	int unsigned sent;

	beeper_envelope_sequencer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("end of test: mismatches");
		$finish;
	end

	// Both monitors sample at the rising edge, before the block's own
	// registers update, so they see exactly what the edge transferred. A
	// result never appears at the edge of its own command, so the order of
	// the two blocks within one step does not matter.
	always @(posedge clk) begin
		if (arst_n && cmd.valid && cmd.ready) board.note_command(cmd.op, cmd.value);
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) board.check_result(rsp.buzzer, rsp.mode);
	end

	// Result side: ready drops in random bursts while idling is allowed, and is
	// otherwise held high.
	initial begin
		int unsigned hold;
		hold      = 0;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold != 0) begin
				hold--;
			end else if (idling && $urandom_range(0, 4) == 0) begin
				hold = $urandom_range(0, 8);
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// Called at a falling edge. Valid is raised once and left high across
	// back-to-back transfers; it is only lowered when a gap follows, so no
	// step ever sees it lowered and raised again.
	task automatic send_command(op_t op, value_t value);
		int unsigned gap;
		cmd.valid <= 1'b1;
		cmd.op    <= op;
		cmd.value <= value;
		do @(posedge clk); while (!cmd.ready);
		@(negedge clk);
		sent++;
		if (idling && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			cmd.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Stop sending and wait until every predicted result has been checked.
	// Every command yields exactly one result, so an empty queue means the
	// block is quiet; the settle time covers the pipeline all the same.
	task automatic drain();
		cmd.valid <= 1'b0;
		while (board.outstanding() != 0) @(posedge clk);
		@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes all four registers on consecutive edges; the enable is lowered
	// only after the last one.
	task automatic configure(reg_t on_min, reg_t on_max, reg_t hyst, reg_t fin_per);
		reg_t data [4];
		data[CFG_ON_MIN]  = on_min;
		data[CFG_ON_MAX]  = on_max;
		data[CFG_HYST]    = hyst;
		data[CFG_FIN_PER] = fin_per;
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			cfg_data  <= data[i];
			@(posedge clk);
			board.write_register(cfg_idx_t'(i), data[i]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// Periods are mostly short so that whole cycles play out in a few ticks;
	// the rest spread over the full range, the ends included.
	function automatic value_t pick_period();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 7) return value_t'($urandom_range(0, 12));
		if (r < 9) return value_t'($urandom);
		return ($urandom_range(0, 1) == 0) ? '0 : '1;
	endfunction

	task automatic random_command();
		int unsigned r;
		int unsigned delta;
		value_t      value;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			send_command(OP_START_PER, pick_period());
		end else if (r < 50) begin
			// Half the retunes land right at the hysteresis boundary.
			if ($urandom_range(0, 1) == 0) begin
				delta = board.hysteresis + $urandom_range(0, 1);
				if ($urandom_range(0, 1) == 0)
					value = value_t'(board.cur_period + delta);
				else
					value = value_t'(board.cur_period - delta);
			end else begin
				value = pick_period();
			end
			send_command(OP_RETUNE, value);
		end else if (r < 60) begin
			send_command(OP_STOP, value_t'($urandom));
		end else if (r < 90) begin
			if ($urandom_range(0, 4) != 0)
				value = value_t'($urandom_range(0, 4));
			else
				value = value_t'($urandom);
			send_command(OP_START_FIN, value);
		end else begin
			// Codes above the last command are ignored by the block.
			send_command(op_t'(OP_START_FIN + $urandom_range(1, 3)), value_t'($urandom));
		end
	endtask

	// A command followed by a run of ticks long enough to let short periods
	// and finite counts play out, with the odd command in the middle. The
	// run is cut short once the requested count has been sent.
	task automatic run_random(int unsigned count);
		int unsigned goal;
		int unsigned run;
		goal = sent + count;
		while (sent < goal) begin
			random_command();
			if ($urandom_range(0, 3) == 0)
				run = $urandom_range(0, 3);
			else
				run = $urandom_range(4, 40);
			repeat (run) begin
				if (sent >= goal) break;
				if ($urandom_range(0, 19) == 0)
					random_command();
				else
					send_command(OP_TICK, value_t'($urandom));
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_ON_MIN;
		cfg_data  = '0;
		cmd.valid = 1'b0;
		cmd.op    = OP_TICK;
		cmd.value = '0;
		idling    = 1'b1;
		sent      = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part on the reset configuration. A tick and the unused
		// codes while idle change nothing.
		send_command(OP_TICK, '1);
		for (op_t o = OP_START_FIN + 3'd1; o != OP_TICK; o++) send_command(o, '1);
		// Retunes while idle: the first stays inside the hysteresis around the
		// reset period, the second just clears it.
		send_command(OP_RETUNE, value_t'(RST_PERIOD + RST_HYST / 2));
		send_command(OP_RETUNE, value_t'(RST_PERIOD + RST_HYST + 1));
		send_command(OP_TICK, '0);
		// A zero period is taken as one tick; the on time is cut to the period.
		send_command(OP_START_PER, '0);
		send_command(OP_TICK, '0);
		send_command(OP_TICK, '0);
		// Longest period, then a retune down to the shortest while the phase
		// is at it, so the next tick ends the cycle at once.
		send_command(OP_START_PER, '1);
		send_command(OP_TICK, '0);
		send_command(OP_RETUNE, '0);
		send_command(OP_TICK, '0);
		send_command(OP_TICK, '0);
		send_command(OP_STOP, '0);
		send_command(OP_TICK, '0);
		// A finite start with a zero count behaves as a stop.
		send_command(OP_START_PER, value_t'(4));
		send_command(OP_START_FIN, '0);
		send_command(OP_START_FIN, '1);
		send_command(OP_TICK, '0);
		send_command(OP_RETUNE, '1);
		send_command(OP_STOP, '1);
		send_command(OP_START_FIN, value_t'(1));
		send_command(OP_STOP, '0);
		run_random(60);

		// Every phase below starts from a drained block; the drain is also the
		// point where the sender holds off until all results are in.
		drain();
		// Zero minimum lets the on time reach zero, so a running buzzer never drops within a period;
		// zero hysteresis accepts any change.
		configure('0, reg_t'(3), '0, reg_t'(1));
		run_random(100);

		drain();
		configure(reg_t'(2), reg_t'(6), reg_t'(1), reg_t'(5));
		run_random(100);

		drain();
		configure('1, '1, '1, '1);
		run_random(60);

		drain();
		// Minimum above maximum, and a zero finite period taken as one.
		configure(reg_t'(5), reg_t'(2), reg_t'(3), '0);
		run_random(100);

		drain();
		configure(reg_t'(1), '1, reg_t'(2), reg_t'(8));
		run_random(100);

		drain();
		// Closing phase at full rate on both sides.
		idling = 1'b0;
		configure(reg_t'(3), reg_t'(1), '0, reg_t'(4));
		run_random(100);

		drain();
		if (board.failures == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

[sim.f]
hw/rtl/beep_pkg.sv
hw/rtl/beep_cmd_if.sv
hw/rtl/beep_rsp_if.sv
hw/rtl/beeper_envelope_sequencer.sv
sim/beeper_envelope_sequencer_tb.sv
